// File: src/kmd_pkg.sv
package kmd_pkg;

  // Number of merge sources the hardware holds heads for
  localparam int SOURCES = 16;
  localparam int SRC_W   = $clog2(SOURCES);
  localparam int CNT_W   = $clog2(SOURCES + 1);

  // Fixed field widths
  localparam int IDX_W  = 4;
  localparam int CFG_W  = 5;
  localparam int WORD_W = 64;
  localparam int ACT_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // Result codes
  typedef enum logic [ACT_W-1:0] {
    ACT_EMIT = 2'd0,
    ACT_DROP = 2'd1,
    ACT_DONE = 2'd2
  } action_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic result_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic all_held;
    logic none_left;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// File: src/kmd_ram.sv
module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/kmd_ctrl.sv
module kmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kmd_pkg::status_t  status,
  output kmd_pkg::cmd_t     cmd
);

  kmd_pkg::state_t state;
  kmd_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kmd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = kmd_pkg::ST_EVAL;
        end
      end
      kmd_pkg::ST_EVAL: begin
        if (!status.all_held) begin
          state_next = kmd_pkg::ST_IDLE;
        end else if (status.none_left) begin
          state_next = kmd_pkg::ST_RESULT;
        end else begin
          state_next = kmd_pkg::ST_SCAN;
        end
      end
      kmd_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = kmd_pkg::ST_DRAIN;
        end
      end
      kmd_pkg::ST_DRAIN: begin
        state_next = kmd_pkg::ST_RESULT;
      end
      kmd_pkg::ST_RESULT: begin
        if (status.out_free) begin
          state_next = kmd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kmd_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready        = (state == kmd_pkg::ST_IDLE);
    cmd.accept      = in_valid && (state == kmd_pkg::ST_IDLE);
    cmd.scan_start  = (state == kmd_pkg::ST_EVAL);
    cmd.scan_step   = (state == kmd_pkg::ST_SCAN);
    cmd.result_load = (state == kmd_pkg::ST_RESULT) && status.out_free;
  end

endmodule

// File: src/kmd_dp.sv
module kmd_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  kmd_pkg::cmd_t               cmd,
  output kmd_pkg::status_t            status,
  input  logic                        cfg_wr_en,
  input  logic [kmd_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic [kmd_pkg::IDX_W-1:0]   source_index,
  input  logic                        end_of_source,
  input  logic [kmd_pkg::WORD_W-1:0]  chain_start,
  input  logic [kmd_pkg::WORD_W-1:0]  chain_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kmd_pkg::ACT_W-1:0]   action,
  output logic [kmd_pkg::WORD_W-1:0]  out_start,
  output logic [kmd_pkg::WORD_W-1:0]  out_key,
  output logic [kmd_pkg::IDX_W-1:0]   next_source
);

  localparam int RAM_W = 2 * kmd_pkg::WORD_W;

  logic [kmd_pkg::CFG_W-1:0]   source_count;
  logic [kmd_pkg::CNT_W-1:0]   active;
  logic [kmd_pkg::SOURCES-1:0] in_use;
  logic [kmd_pkg::SOURCES-1:0] need;
  logic [kmd_pkg::SOURCES-1:0] present;
  logic [kmd_pkg::SOURCES-1:0] finished;
  logic [kmd_pkg::SRC_W-1:0]   src;
  logic                        src_ok;
  logic                        ram_we;
  logic [RAM_W-1:0]            ram_rdata;
  logic [kmd_pkg::WORD_W-1:0]  rd_key;
  logic [kmd_pkg::WORD_W-1:0]  rd_start;
  logic [kmd_pkg::SRC_W-1:0]   scan_idx;
  logic [kmd_pkg::SRC_W-1:0]   rd_idx;
  logic                        rd_pend;
  logic                        found;
  logic [kmd_pkg::WORD_W-1:0]  best_key;
  logic [kmd_pkg::WORD_W-1:0]  best_start;
  logic [kmd_pkg::SRC_W-1:0]   best_idx;
  logic [kmd_pkg::WORD_W-1:0]  last_key;
  logic                        last_valid;
  logic                        is_dup;

  // Source count register
  always_ff @(posedge clk) begin
    if (rst) begin
      source_count <= kmd_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      source_count <= cfg_wr_data;
    end
  end

  // Effective count and in-use mask
  always_comb begin
    if (int'(source_count) > kmd_pkg::SOURCES) begin
      active = kmd_pkg::CNT_W'(kmd_pkg::SOURCES);
    end else begin
      active = kmd_pkg::CNT_W'(source_count);
    end
    for (int i = 0; i < kmd_pkg::SOURCES; i++) begin
      in_use[i] = (i < int'(active));
    end
  end

  // Incoming transaction qualification
  assign src    = kmd_pkg::SRC_W'(source_index);
  assign src_ok = (int'(source_index) < int'(active)) && !present[src] && !finished[src];
  assign ram_we = cmd.accept && src_ok && !end_of_source;

  // Merge readiness
  assign need             = in_use & ~finished;
  assign status.all_held  = ((need & ~present) == '0);
  assign status.none_left = (need == '0);
  assign status.scan_last = (scan_idx == kmd_pkg::SRC_W'(active - kmd_pkg::CNT_W'(1)));
  assign status.out_free  = !out_valid || out_ready;

  // Per-source head and end flags
  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= '0;
      finished <= '0;
    end else begin
      if (cmd.accept && src_ok) begin
        if (end_of_source) begin
          finished[src] <= 1'b1;
        end else begin
          present[src] <= 1'b1;
        end
      end
      if (cmd.result_load && found) begin
        present[best_idx] <= 1'b0;
      end
    end
  end

  // Head record store, {start, key} per source
  kmd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (kmd_pkg::SOURCES)
  ) u_head_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (src),
    .wdata ({chain_start, chain_key}),
    .re    (cmd.scan_step),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  assign rd_start = ram_rdata[RAM_W-1:kmd_pkg::WORD_W];
  assign rd_key   = ram_rdata[kmd_pkg::WORD_W-1:0];

  // Scan sequencer: one head read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + kmd_pkg::SRC_W'(1);
      rd_pend  <= 1'b1;
    end else begin
      rd_pend  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_idx <= scan_idx;
    end
  end

  // Running minimum; strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.scan_start) begin
      found <= 1'b0;
    end else if (rd_pend && present[rd_idx] && (!found || rd_key < best_key)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend && present[rd_idx] && (!found || rd_key < best_key)) begin
      best_key   <= rd_key;
      best_start <= rd_start;
      best_idx   <= rd_idx;
    end
  end

  assign is_dup = last_valid && (best_key == last_key);

  // Last emitted key
  always_ff @(posedge clk) begin
    if (rst) begin
      last_key   <= '0;
      last_valid <= 1'b0;
    end else if (cmd.result_load && found && !is_dup) begin
      last_key   <= best_key;
      last_valid <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      if (found) begin
        action      <= is_dup ? kmd_pkg::ACT_DROP : kmd_pkg::ACT_EMIT;
        out_start   <= best_start;
        out_key     <= best_key;
        next_source <= kmd_pkg::IDX_W'(best_idx);
      end else begin
        action      <= kmd_pkg::ACT_DONE;
        out_start   <= '0;
        out_key     <= '0;
        next_source <= '0;
      end
    end
  end

endmodule

// File: src/kway_merge_dedup_by_key.sv
// K-way merge with duplicate-key removal. Each transaction on the input delivers
// either the next record of a source or an end marker for it. Once every unfinished
// source in use holds a head record, the block scans the head store (one entry per
// cycle from the head RAM read port) for the smallest key, lowest source on ties,
// and returns that record as emitted or as a dropped duplicate of the last emitted
// key, with next_source naming the source to feed next; when all sources in use
// have ended it returns a done result. A transaction that completes no merge returns
// from EVAL to IDLE; one that ends all sources goes from EVAL to RESULT; one that
// triggers a merge passes through SCAN over the N effective sources, DRAIN and RESULT.
// The output register lets a result wait while the next transaction is accepted.
module kway_merge_dedup_by_key (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [kmd_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kmd_pkg::IDX_W-1:0]   source_index,
  input  logic                        end_of_source,
  input  logic [kmd_pkg::WORD_W-1:0]  chain_start,
  input  logic [kmd_pkg::WORD_W-1:0]  chain_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kmd_pkg::ACT_W-1:0]   action,
  output logic [kmd_pkg::WORD_W-1:0]  out_start,
  output logic [kmd_pkg::WORD_W-1:0]  out_key,
  output logic [kmd_pkg::IDX_W-1:0]   next_source
);

  kmd_pkg::cmd_t    cmd;
  kmd_pkg::status_t status;

  // Sequencer
  kmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Head store, scan and result path
  kmd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .source_index  (source_index),
    .end_of_source (end_of_source),
    .chain_start   (chain_start),
    .chain_key     (chain_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .out_start     (out_start),
    .out_key       (out_key),
    .next_source   (next_source)
  );

endmodule

// File: src/kmd_checker.sv
module kmd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kmd_pkg::ACT_W-1:0]   action,
  input logic [kmd_pkg::WORD_W-1:0]  out_start,
  input logic [kmd_pkg::WORD_W-1:0]  out_key,
  input logic [kmd_pkg::IDX_W-1:0]   next_source
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(out_start)
      && $stable(out_key) && $stable(next_source))
    else $error("stalled result changed");

  // One transaction at a time: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // A done result carries zero fields
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == kmd_pkg::ACT_DONE) |->
      (out_start == '0) && (out_key == '0) && (next_source == '0))
    else $error("done result with nonzero fields");

endmodule

bind kway_merge_dedup_by_key kmd_checker u_kmd_checker (.*);

// File: verif/tb_kway_merge_dedup_by_key.sv
module tb_kway_merge_dedup_by_key;

  localparam int QUIET_LIMIT = 2000;  // cycles with no transaction before giving up
  localparam int SETTLE      = 30;    // covers the longest merge, a scan over all SOURCES heads
  localparam int LONG_HOLD   = 400;

  // One merge result as seen on the output port
  typedef struct {
    kmd_pkg::action_t           act;
    logic [kmd_pkg::WORD_W-1:0] start;
    logic [kmd_pkg::WORD_W-1:0] key;
    logic [kmd_pkg::IDX_W-1:0]  src;
  } merge_result_t;

  // Tracks heads, finished sources and the last emitted key; predicts merge results
  class merge_scoreboard;
    bit                         held[kmd_pkg::SOURCES];
    bit                         ended[kmd_pkg::SOURCES];
    logic [kmd_pkg::WORD_W-1:0] head_key[kmd_pkg::SOURCES];
    logic [kmd_pkg::WORD_W-1:0] head_start[kmd_pkg::SOURCES];
    logic [kmd_pkg::WORD_W-1:0] last_key;
    bit                         last_valid;
    bit [kmd_pkg::CFG_W-1:0]    count;
    merge_result_t              merges_due[$];
    int                         errors;

    function new();
      int i;
      for (i = 0; i < kmd_pkg::SOURCES; i++) begin
        held[i]  = 1'b0;
        ended[i] = 1'b0;
      end
      last_key   = '0;
      last_valid = 1'b0;
      count      = kmd_pkg::CFG_RESET;
      errors     = 0;
    endfunction

    function void set_count(bit [kmd_pkg::CFG_W-1:0] value);
      count = value;
    endfunction

    function int in_use();
      return (count > kmd_pkg::SOURCES) ? kmd_pkg::SOURCES : int'(count);
    endfunction

    function bit wants_head(int i);
      return i < in_use() && !ended[i] && !held[i];
    endfunction

    function int pending();
      return merges_due.size();
    endfunction

    // Accepted input transaction: update heads, then run one merge evaluation
    function void note_record(bit [kmd_pkg::IDX_W-1:0] src, bit eos,
                              logic [kmd_pkg::WORD_W-1:0] start,
                              logic [kmd_pkg::WORD_W-1:0] key);
      int            n;
      int            i;
      int            best;
      bit            found;
      merge_result_t r;
      n = in_use();
      if (src < n && !held[src] && !ended[src]) begin
        if (eos) begin
          ended[src] = 1'b1;
        end else begin
          held[src]       = 1'b1;
          head_start[src] = start;
          head_key[src]   = key;
        end
      end
      found = 1'b0;
      best  = 0;
      for (i = 0; i < n; i++) begin
        if (ended[i]) continue;
        if (!held[i]) return;  // still waiting on a head
        if (!found || head_key[i] < head_key[best]) begin
          best  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.act   = kmd_pkg::ACT_DONE;
        r.start = '0;
        r.key   = '0;
        r.src   = '0;
      end else begin
        r.start = head_start[best];
        r.key   = head_key[best];
        r.src   = best[kmd_pkg::IDX_W-1:0];
        if (last_valid && head_key[best] == last_key) begin
          r.act = kmd_pkg::ACT_DROP;
        end else begin
          r.act      = kmd_pkg::ACT_EMIT;
          last_key   = head_key[best];
          last_valid = 1'b1;
        end
        held[best] = 1'b0;
      end
      merges_due.insert(merges_due.size(), r);
    endfunction

    // Accepted output transaction: compare against the oldest prediction
    function void check_output(logic [kmd_pkg::ACT_W-1:0] act,
                               logic [kmd_pkg::WORD_W-1:0] start,
                               logic [kmd_pkg::WORD_W-1:0] key,
                               logic [kmd_pkg::IDX_W-1:0] src);
      merge_result_t e;
      if (merges_due.size() == 0) begin
        $error("unexpected result: action %0d key %h", act, key);
        errors++;
        return;
      end
      e = merges_due.pop_front();
      if (act !== e.act) begin
        $error("action: expected %0d, got %0d", e.act, act);
        errors++;
      end
      if (start !== e.start) begin
        $error("out_start: expected %h, got %h", e.start, start);
        errors++;
      end
      if (key !== e.key) begin
        $error("out_key: expected %h, got %h", e.key, key);
        errors++;
      end
      if (src !== e.src) begin
        $error("next_source: expected %0d, got %0d", e.src, src);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [kmd_pkg::CFG_W-1:0]  cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [kmd_pkg::IDX_W-1:0]  source_index;
  logic                       end_of_source;
  logic [kmd_pkg::WORD_W-1:0] chain_start;
  logic [kmd_pkg::WORD_W-1:0] chain_key;
  logic                       out_valid;
  logic                       out_ready;
  logic [kmd_pkg::ACT_W-1:0]  action;
  logic [kmd_pkg::WORD_W-1:0] out_start;
  logic [kmd_pkg::WORD_W-1:0] out_key;
  logic [kmd_pkg::IDX_W-1:0]  next_source;

  merge_scoreboard            sb;
  bit                         tx_idle;
  bit                         rx_idle;
  bit                         hold_long;
  int                         rx_hold;
  int                         quiet;
  logic [kmd_pkg::WORD_W-1:0] stream_key[kmd_pkg::SOURCES];
  int                         stream_left[kmd_pkg::SOURCES];

  kway_merge_dedup_by_key u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .source_index  (source_index),
    .end_of_source (end_of_source),
    .chain_start   (chain_start),
    .chain_key     (chain_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .out_start     (out_start),
    .out_key       (out_key),
    .next_source   (next_source)
  );

  always #2 clk = ~clk;

  function automatic logic [kmd_pkg::WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one input transaction, with an optional gap first, and wait for acceptance
  task automatic send_item(input bit [kmd_pkg::IDX_W-1:0] src, input bit eos,
                           input logic [kmd_pkg::WORD_W-1:0] start,
                           input logic [kmd_pkg::WORD_W-1:0] key);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    source_index  <= src;
    end_of_source <= eos;
    chain_start   <= start;
    chain_key     <= key;
    do @(posedge clk); while (!in_ready);
    sb.note_record(src, eos, start, key);
  endtask

  task automatic send_noise();
    send_item(kmd_pkg::IDX_W'($urandom_range(0, kmd_pkg::SOURCES - 1)),
              1'($urandom_range(0, 1)), rand64(), rand64());
  endtask

  // Register write once the block has drained and settled
  task automatic set_source_count(input bit [kmd_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_count(value);
  endtask

  // Feed sorted streams to whichever sources the merge waits on, with some noise.
  // A budget of zero runs until every source in use has ended.
  task automatic run_phase(input bit [kmd_pkg::CFG_W-1:0] cnt, input int budget,
                           input bit squeeze);
    int                         sent;
    int                         pick;
    int                         left;
    int                         i;
    int                         cand[$];
    logic [kmd_pkg::WORD_W-1:0] k;
    set_source_count(cnt);
    if (squeeze) hold_long = 1'b1;
    sent = 0;
    while (budget == 0 || sent < budget) begin
      cand.delete();
      left = 0;
      for (i = 0; i < kmd_pkg::SOURCES; i++) begin
        if (sb.wants_head(i)) cand.insert(cand.size(), i);
        // records still to come from sources that have not ended
        if (!sb.ended[i]) left += stream_left[i];
      end
      if (cand.size() == 0) break;
      // quiet tail: no idling on either side
      if (budget == 0 && left < 60) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        pick = cand[$urandom_range(0, cand.size() - 1)];
        if (stream_left[pick] == 0) begin
          send_item(pick[kmd_pkg::IDX_W-1:0], 1'b1, rand64(), rand64());
        end else begin
          k = stream_key[pick] + (($urandom_range(0, 19) == 0) ? 64'($urandom)
                                                                : 64'($urandom_range(0, 3)));
          if (k < stream_key[pick]) k = '1;
          stream_key[pick] = k;
          stream_left[pick]--;
          send_item(pick[kmd_pkg::IDX_W-1:0], 1'b0, rand64(), k);
        end
        sent++;
      end
    end
    repeat (2) send_noise();
  endtask

  // Output side: check accepted results, stall in random bursts or one long hold
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_output(action, out_start, out_key, next_source);
      end
      if (rx_hold == 0) begin
        if (hold_long) begin
          hold_long = 1'b0;
          rx_hold   = LONG_HOLD;
        end else if (rx_idle && $urandom_range(0, 7) == 0) begin
          rx_hold = $urandom_range(1, 7);
        end
      end
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_kway_merge_dedup_by_key: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [kmd_pkg::WORD_W-1:0] base;
    int                         i;
    sb            = new();
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    source_index  = '0;
    end_of_source = 1'b0;
    chain_start   = '0;
    chain_key     = '0;
    out_ready     = 1'b0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    hold_long     = 1'b0;
    rx_hold       = 0;
    quiet         = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset count of 16: heads for sources 15 and 0, then a repeat while 15 holds
    send_item(4'd15, 1'b0, '1, '1);
    send_item(4'd0, 1'b0, '0, '0);
    send_item(4'd15, 1'b0, rand64(), 64'd7);

    // One source: unused-source item still merges, duplicate of key 0, done repeated
    set_source_count(5'd1);
    send_item(4'd3, 1'b0, rand64(), 64'd1);
    send_item(4'd0, 1'b0, rand64(), 64'd0);
    send_item(4'd0, 1'b0, rand64(), 64'd5);
    send_item(4'd0, 1'b1, rand64(), rand64());
    send_item(4'd0, 1'b0, rand64(), 64'd9);

    // No source in use: every transaction reports done
    set_source_count(5'd0);
    send_item(4'd15, 1'b0, rand64(), rand64());
    send_item(4'd9, 1'b1, rand64(), rand64());

    // Sources 1 and 2: equal keys go to the lower index, then an all-ones key
    set_source_count(5'd3);
    send_item(4'd1, 1'b0, rand64(), 64'd100);
    send_item(4'd2, 1'b0, rand64(), 64'd100);
    send_item(4'd1, 1'b0, rand64(), 64'd100);
    send_item(4'd1, 1'b1, rand64(), rand64());
    send_item(4'd2, 1'b0, rand64(), '1);
    send_item(4'd2, 1'b1, rand64(), rand64());

    // Random streams share one base so keys collide across sources
    base = rand64() >> 1;
    for (i = 0; i < kmd_pkg::SOURCES; i++) begin
      stream_key[i]  = base + 64'($urandom_range(0, 8));
      stream_left[i] = (i < 3) ? 0 : $urandom_range(30, 110);
    end
    run_phase(5'd8, 150, 1'b0);
    run_phase(5'd6, 100, 1'b0);    // count lowered mid-stream
    run_phase(5'd12, 200, 1'b1);   // raised again, with a long output hold
    run_phase(5'd31, 0, 1'b0);     // above the source count, run to done

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_kway_merge_dedup_by_key: clean");
    end else begin
      $display("tb_kway_merge_dedup_by_key: errors");
    end
    $finish;
  end

endmodule
